// ===== src/scalar_kalman_filter_macros.svh =====
// scalar_kalman_filter_macros.svh: assertion macros for the scalar kalman filter checker
// expects clk and arst_n to be visible where the macros are used
`ifndef SCALAR_KALMAN_FILTER_MACROS_SVH
`define SCALAR_KALMAN_FILTER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SKF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define SKF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/skf_pkg.sv =====
// skf_pkg: widths, reset values, register indexes and beat types of the scalar kalman filter
// no dependencies; imported by every module of the block
package skf_pkg;

	localparam int DATA_W  = 32;
	localparam int FRAC_W  = 16;
	localparam int GAIN_W  = FRAC_W + 1;

	// fixed point one and the reset values of the registers
	localparam logic [GAIN_W-1:0] ONE_G      = GAIN_W'(1) << FRAC_W;
	localparam logic [DATA_W-1:0] ONE_FX     = DATA_W'(1) << FRAC_W;
	localparam logic [DATA_W-1:0] RST_EST    = ONE_FX;
	localparam logic [DATA_W-1:0] RST_VAR    = ONE_FX;
	localparam logic [DATA_W-1:0] RST_QNOISE = ONE_FX >> 1;
	localparam logic [DATA_W-1:0] RST_RNOISE = (ONE_FX + DATA_W'(5)) / DATA_W'(10);

	// register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_EST = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_VAR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_QNOISE   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RNOISE   = 2'd3;

	// restoring divider: integer bit plus one bit per fraction bit
	localparam int DIV_STEPS = FRAC_W + 1;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef struct packed {
		logic signed [DATA_W-1:0] measurement;
		logic                     sample_missing;
	} skf_in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] estimate;
		logic        [DATA_W-1:0] variance;
		logic        [GAIN_W-1:0] gain;
	} skf_out_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;    // capture the input beat
		logic pred;    // predicted variance and divider setup
		logic div;     // one divider step
		logic mule;    // gain times innovation magnitude
		logic mulv;    // estimate update and variance product
		logic commit;  // write state and output register
	} skf_cmd_t;

endpackage

// ===== src/skf_ctrl.sv =====
// skf_ctrl: sequencer of the scalar kalman filter, owns the handshakes
// depends on skf_pkg
module skf_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output skf_pkg::skf_cmd_t cmd
);
	import skf_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PRED = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_MULE = 3'd3;
	localparam logic [2:0] S_MULV = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

	logic [2:0]           state_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 out_valid_q;
	logic                 commit;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	// output slot free, or being emptied this cycle
	assign commit    = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		cmd        = '0;
		cmd.load   = in_ready && in_valid;
		cmd.pred   = (state_q == S_PRED);
		cmd.div    = (state_q == S_DIV);
		cmd.mule   = (state_q == S_MULE);
		cmd.mulv   = (state_q == S_MULV);
		cmd.commit = commit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_PRED;
					end
				end
				S_PRED: begin
					div_cnt_q <= '0;
					state_q   <= S_DIV;
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
					if (div_cnt_q == DIV_LAST) begin
						state_q <= S_MULE;
					end
				end
				S_MULE: state_q <= S_MULV;
				S_MULV: state_q <= S_DONE;
				S_DONE: begin
					if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== src/skf_datapath.sv =====
// skf_datapath: registers, filter state, restoring divider and shared multiplier
// depends on skf_pkg; driven by skf_ctrl commands
module skf_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  skf_pkg::skf_cmd_t           cmd,
	input  skf_pkg::skf_in_t            in_data,
	input  logic                        cfg_we,
	input  logic [skf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [skf_pkg::DATA_W-1:0]  cfg_wdata,
	output skf_pkg::skf_out_t           out_data
);
	import skf_pkg::*;

	localparam int DEN_W  = DATA_W + 1;
	localparam int REM_W  = DATA_W + 2;
	localparam int MAG_W  = DATA_W + 1;
	localparam int PROD_W = MAG_W + GAIN_W;
	localparam int SUM_W  = DATA_W + 2;

	// configuration and filter state
	logic [DATA_W-1:0] qnoise_q, rnoise_q;
	logic [DATA_W-1:0] est_q, var_q;

	// per-item working registers
	logic [DATA_W-1:0] meas_q, ppred_q, nest_q;
	logic [DEN_W-1:0]  den_q;
	logic              den_zero_q;
	logic [REM_W-1:0]  rem_q;
	logic [GAIN_W-1:0] quo_q;
	logic [PROD_W-1:0] prod_q;
	logic              neg_q;
	skf_out_t          out_q;

	logic [DATA_W:0]   sum_pq;
	logic [DATA_W-1:0] ppred_w;
	logic [DEN_W-1:0]  den_w;
	logic              ge;
	logic [REM_W-1:0]  rem_sub;
	logic [GAIN_W-1:0] gain_w;
	logic [MAG_W-1:0]  diff, mag;
	logic [MAG_W-1:0]  mul_a;
	logic [GAIN_W-1:0] mul_b;
	logic [PROD_W-1:0] product;
	logic [MAG_W-1:0]  corr;
	logic [SUM_W-1:0]  est_ext, nest_sum;

	always_comb begin
		// saturating prediction of the variance
		sum_pq  = {1'b0, var_q} + {1'b0, qnoise_q};
		ppred_w = sum_pq[DATA_W] ? '1 : sum_pq[DATA_W-1:0];
		den_w   = {1'b0, ppred_w} + {1'b0, rnoise_q};

		// one restoring step
		ge      = (rem_q >= REM_W'(den_q));
		rem_sub = ge ? (rem_q - REM_W'(den_q)) : rem_q;
		gain_w  = den_zero_q ? '0 : quo_q;

		// innovation magnitude and sign
		diff = {meas_q[DATA_W-1], meas_q} - {est_q[DATA_W-1], est_q};
		mag  = diff[MAG_W-1] ? (~diff + MAG_W'(1)) : diff;

		// shared multiplier
		if (cmd.mulv) begin
			mul_a = {1'b0, ppred_q};
			mul_b = ONE_G - gain_w;
		end else begin
			mul_a = mag;
			mul_b = gain_w;
		end
		product = PROD_W'(mul_a) * PROD_W'(mul_b);

		// correction is at most the magnitude, so the estimate stays in range
		corr     = prod_q[FRAC_W +: MAG_W];
		est_ext  = {{2{est_q[DATA_W-1]}}, est_q};
		nest_sum = neg_q ? (est_ext - SUM_W'(corr)) : (est_ext + SUM_W'(corr));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qnoise_q   <= RST_QNOISE;
			rnoise_q   <= RST_RNOISE;
			est_q      <= RST_EST;
			var_q      <= RST_VAR;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_INIT_EST: est_q    <= cfg_wdata;
					CFG_INIT_VAR: var_q    <= cfg_wdata;
					CFG_QNOISE:   qnoise_q <= cfg_wdata;
					CFG_RNOISE:   rnoise_q <= cfg_wdata;
					default: ;
				endcase
			end else if (cmd.commit) begin
				est_q <= nest_q;
				var_q <= prod_q[FRAC_W +: DATA_W];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			meas_q <= in_data.sample_missing ? est_q : in_data.measurement;
		end
		if (cmd.pred) begin
			ppred_q    <= ppred_w;
			den_q      <= den_w;
			den_zero_q <= (den_w == '0);
			rem_q      <= REM_W'(ppred_w);
			quo_q      <= '0;
		end
		if (cmd.div) begin
			rem_q <= {rem_sub[REM_W-2:0], 1'b0};
			quo_q <= {quo_q[GAIN_W-2:0], ge};
		end
		if (cmd.mule) begin
			prod_q <= product;
			neg_q  <= diff[MAG_W-1];
		end
		if (cmd.mulv) begin
			nest_q <= nest_sum[DATA_W-1:0];
			prod_q <= product;
		end
		if (cmd.commit) begin
			out_q.estimate <= nest_q;
			out_q.variance <= prod_q[FRAC_W +: DATA_W];
			out_q.gain     <= gain_w;
		end
	end

	assign out_data = out_q;

endmodule

// ===== src/scalar_kalman_filter.sv =====
// scalar_kalman_filter: top level of the one-dimensional kalman filter, q16.16
// depends on skf_pkg, skf_ctrl and skf_datapath
//
//  channel   direction  handshake             payload
//  in        into       in_valid / in_ready    in_data   (skf_in_t)
//  out       out of     out_valid / out_ready  out_data  (skf_out_t)
//  cfg       into       cfg_we                 cfg_index, cfg_wdata
//
// after acceptance, an input beat passes through one predict step, 17 steps of the
// restoring gain divider, two passes through the shared multiplier and one commit;
// the block then returns to idle before it takes the next input beat.
// the result is loaded into the output register at the commit.
// a stalled output beat holds the commit; the next input beat is not taken
// while it waits. reset reloads the filter state from the register reset values.
module scalar_kalman_filter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  skf_pkg::skf_in_t              in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output skf_pkg::skf_out_t             out_data,
	input  logic                          cfg_we,
	input  logic [skf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [skf_pkg::DATA_W-1:0]    cfg_wdata
);
	import skf_pkg::*;

	// command bundle from the sequencer to the datapath
	skf_cmd_t cmd;

	// sequencer: handshakes, divider step count, output beat valid
	skf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// datapath: registers, estimate and variance state, divider, multiplier
	skf_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.out_data  (out_data)
	);

endmodule

// ===== src/skf_checker.sv =====
// skf_checker: port-level assertions for the scalar kalman filter, bound to the top level
// depends on skf_pkg and scalar_kalman_filter_macros.svh
`include "scalar_kalman_filter_macros.svh"

module skf_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input skf_pkg::skf_out_t             out_data
);
	import skf_pkg::*;

	// a waiting output beat holds
	`SKF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "output beat changed while stalled")
	// one item at a time: busy right after an accepted input beat
	`SKF_ASSERT_NXT(a_busy_after_in, in_valid && in_ready, !in_ready && !$rose(out_valid), "input taken while busy or result too early")
	// a new result goes with the block becoming free
	`SKF_ASSERT_IMP(a_done_free, $rose(out_valid), in_ready, "result shown while still busy")
	// gain never exceeds one
	`SKF_ASSERT_IMP(a_gain_max, out_valid, out_data.gain <= ONE_G, "gain above one")

endmodule

bind scalar_kalman_filter skf_checker u_skf_checker (.*);
